// ===== src/hrlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrlc_pkg
// Shared types and constants of the request-line checker.
// ----------------------------------------------------------------------------
package hrlc_pkg;

  localparam int LEN_BITS = 12;
  localparam int RAW_BITS = LEN_BITS + 1;
  localparam logic [RAW_BITS-1:0] RAW_CAP = RAW_BITS'(1) << LEN_BITS;
  localparam logic [LEN_BITS-1:0] CFG_RESET = LEN_BITS'(2048);

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_REQ    = 3'd1;
  localparam logic [2:0] ST_FORBIDDEN  = 3'd2;
  localparam logic [2:0] ST_BAD_METHOD = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;
  localparam logic [2:0] ST_BAD_VER    = 3'd5;

  localparam logic [1:0] METH_NONE   = 2'd0;
  localparam logic [1:0] METH_GET    = 2'd1;
  localparam logic [1:0] METH_POST   = 2'd2;
  localparam logic [1:0] METH_DELETE = 2'd3;

  localparam logic [1:0] EXT_NONE = 2'd0;
  localparam logic [1:0] EXT_PHP  = 2'd1;
  localparam logic [1:0] EXT_PY   = 2'd2;

  // target error bits
  localparam int TE_SLASH = 0;
  localparam int TE_CHAR  = 1;
  localparam int TE_LONG  = 2;

  // decoded-target tracking
  typedef struct packed {
    logic [LEN_BITS-1:0] count;
    logic                q_found;
    logic [LEN_BITS-1:0] q_pos;
    logic                dot_pair;
    logic [2:0][7:0]     win;
    logic                dot_seen;
    logic [2:0][7:0]     after;
    logic [1:0]          after_cnt;
    logic                php_found;
    logic [LEN_BITS-1:0] php_end;
    logic                py_found;
    logic [LEN_BITS-1:0] py_end;
  } dec_st_t;

  typedef struct packed {
    logic [1:0]          tok_idx;
    logic                in_sep;
    logic                past3;
    logic [RAW_BITS-1:0] tcnt;
    logic [2:0]          meth_bits;
    logic [1:0]          meth_found;
    logic                ver_match;
    logic                ver_ok;
    logic                tgt_seen;
    logic [2:0]          tgt_err;
    logic [1:0]          hold_cnt;
    logic [7:0]          hold1;
    dec_st_t             dec;
  } line_st_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [1:0]          method_kind;
    logic [1:0]          ext_kind;
    logic [LEN_BITS-1:0] path_length;
    logic [LEN_BITS-1:0] script_length;
    logic [LEN_BITS-1:0] decoded_length;
    logic                has_question;
  } result_t;

endpackage
`default_nettype wire

// ===== src/hrlc_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrlc_scan
// Per-byte tokenizer, matchers and target decoder; builds the line result.
// ----------------------------------------------------------------------------
module hrlc_scan (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [7:0]                   byte_in,
  input  wire logic                         last_in,
  input  wire logic [hrlc_pkg::LEN_BITS-1:0] max_len,
  output hrlc_pkg::result_t                 res
);
  import hrlc_pkg::*;

  line_st_t st_r, st_nxt;

  function automatic line_st_t clear_line();
    line_st_t s;
    s = '0;
    s.in_sep = 1'b1;
    s.meth_bits = 3'b111;
    s.ver_match = 1'b1;
    return s;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic logic allowed(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
           b == "~" || b == "!" || (b >= "#" && b <= "/") || b == ":" || b == ";" ||
           b == "=" || b == "?" || b == "@" || b == "[" || b == "]" || b == "_";
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= "0" && b <= "9") begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end else if (b >= "a" && b <= "f") begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end else if (b >= "A" && b <= "F") begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
    logic [4:0] h1, h2;
    h1 = hex_val(c1);
    h2 = hex_val(c2);
    if (h1[4]) return h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]};
    if (c1 == "+") return h2[4] ? {4'd0, h2[3:0]} : 8'd0;
    if (c1 == "-") return h2[4] ? 8'(8'd0 - {4'd0, h2[3:0]}) : 8'd0;
    return 8'd0;
  endfunction

  function automatic dec_st_t emit(input dec_st_t d_in, input logic [7:0] b);
    dec_st_t d;
    logic [LEN_BITS-1:0] nxt;
    d = d_in;
    nxt = (d.count != '1) ? d.count + LEN_BITS'(1) : d.count;
    if (!d.q_found) begin
      if (b == "?") begin
        d.q_found = 1'b1;
        d.q_pos = d.count;
      end else begin
        if (b == "." && d.win[2] == ".") d.dot_pair = 1'b1;
        if (b == ".") begin
          d.dot_seen = 1'b1;
          d.after_cnt = 2'd0;
        end else if (d.dot_seen && d.after_cnt != 2'd3) begin
          d.after[d.after_cnt] = b;
          d.after_cnt = d.after_cnt + 2'd1;
        end
        if (!d.php_found && d.win[0] == "." && d.win[1] == "p" && d.win[2] == "h" &&
            b == "p") begin
          d.php_found = 1'b1;
          d.php_end = nxt;
        end
        if (!d.py_found && d.win[1] == "." && d.win[2] == "p" && b == "y") begin
          d.py_found = 1'b1;
          d.py_end = nxt;
        end
        d.win = {b, d.win[2], d.win[1]};
      end
    end
    d.count = nxt;
    return d;
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] b);
    return (b == "+") ? 8'h20 : b;
  endfunction

  function automatic logic [7:0] word_ch(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      2'd0: begin
        case (p)
          3'd0: c = "G";
          3'd1: c = "E";
          3'd2: c = "T";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (p)
          3'd0: c = "P";
          3'd1: c = "O";
          3'd2: c = "S";
          3'd3: c = "T";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (p)
          3'd0: c = "D";
          3'd1: c = "E";
          3'd2: c = "L";
          3'd3: c = "E";
          3'd4: c = "T";
          3'd5: c = "E";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (p)
          3'd0: c = "H";
          3'd1: c = "T";
          3'd2: c = "T";
          3'd3: c = "P";
          3'd4: c = "/";
          3'd5: c = "1";
          3'd6: c = ".";
          3'd7: c = "1";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic line_st_t end_token(input line_st_t s_in, input logic [LEN_BITS-1:0] mx);
    line_st_t s;
    s = s_in;
    if (s.tok_idx == 2'd1) begin
      if (s.meth_bits[0] && s.tcnt == RAW_BITS'(3)) s.meth_found = METH_GET;
      else if (s.meth_bits[1] && s.tcnt == RAW_BITS'(4)) s.meth_found = METH_POST;
      else if (s.meth_bits[2] && s.tcnt == RAW_BITS'(6)) s.meth_found = METH_DELETE;
    end else if (s.tok_idx == 2'd2) begin
      // unfinished escape is kept literally
      if (s.hold_cnt != 2'd0) s.dec = emit(s.dec, "%");
      if (s.hold_cnt == 2'd2) s.dec = emit(s.dec, plain(s.hold1));
      s.hold_cnt = 2'd0;
      if (s.tcnt > {1'b0, mx}) s.tgt_err[TE_LONG] = 1'b1;
      s.tgt_seen = 1'b1;
    end else if (s.tok_idx == 2'd3) begin
      s.ver_ok = s.ver_match && s.tcnt == RAW_BITS'(8);
      s.past3 = 1'b1;
    end
    s.in_sep = 1'b1;
    return s;
  endfunction

  function automatic line_st_t word_byte(input line_st_t s_in, input logic [7:0] b);
    line_st_t s;
    logic [RAW_BITS-1:0] p;
    s = s_in;
    p = s.tcnt;
    if (s.tok_idx == 2'd1) begin
      if (p >= RAW_BITS'(3) || word_ch(2'd0, p[2:0]) != b) s.meth_bits[0] = 1'b0;
      if (p >= RAW_BITS'(4) || word_ch(2'd1, p[2:0]) != b) s.meth_bits[1] = 1'b0;
      if (p >= RAW_BITS'(6) || word_ch(2'd2, p[2:0]) != b) s.meth_bits[2] = 1'b0;
    end else if (s.tok_idx == 2'd2) begin
      if (p == '0 && b != "/") s.tgt_err[TE_SLASH] = 1'b1;
      if (!allowed(b)) s.tgt_err[TE_CHAR] = 1'b1;
      if (s.hold_cnt == 2'd0) begin
        if (b == "%") s.hold_cnt = 2'd1;
        else s.dec = emit(s.dec, plain(b));
      end else if (s.hold_cnt == 2'd1) begin
        s.hold1 = b;
        s.hold_cnt = 2'd2;
      end else begin
        s.dec = emit(s.dec, decode_pair(s.hold1, b));
        s.hold_cnt = 2'd0;
      end
    end else if (s.tok_idx == 2'd3) begin
      if (p >= RAW_BITS'(8) || word_ch(2'd3, p[2:0]) != b) s.ver_match = 1'b0;
    end
    return s;
  endfunction

  line_st_t s;
  always_comb begin
    s = st_r;
    res = '0;
    if (is_space(byte_in)) begin
      if (!s.in_sep) s = end_token(s, max_len);
    end else if (!s.past3) begin
      if (s.in_sep) begin
        s.tok_idx = s.tok_idx + 2'd1;
        s.tcnt = '0;
        s.in_sep = 1'b0;
      end
      s = word_byte(s, byte_in);
      if (s.tcnt < RAW_CAP) s.tcnt = s.tcnt + RAW_BITS'(1);
    end
    if (last_in && !s.in_sep && !s.past3) s = end_token(s, max_len);

    if (!s.past3) res.status = ST_BAD_REQ;
    else if (s.meth_found == METH_NONE) res.status = ST_BAD_METHOD;
    else if (!s.ver_ok) res.status = ST_BAD_VER;
    else if (!s.tgt_seen || s.tgt_err[TE_LONG]) res.status = ST_TOO_LONG;
    else if (s.tgt_err[TE_SLASH] || s.tgt_err[TE_CHAR]) res.status = ST_BAD_REQ;
    else if (s.dec.dot_pair) res.status = ST_FORBIDDEN;
    else res.status = ST_OK;

    if (res.status == ST_OK) begin
      res.method_kind = s.meth_found;
      if (s.dec.dot_seen && s.dec.after_cnt == 2'd3 && s.dec.after[0] == "p" &&
          s.dec.after[1] == "h" && s.dec.after[2] == "p") begin
        res.ext_kind = EXT_PHP;
        res.script_length = s.dec.php_end;
      end else if (s.dec.dot_seen && s.dec.after_cnt == 2'd2 && s.dec.after[0] == "p" &&
                   s.dec.after[1] == "y") begin
        res.ext_kind = EXT_PY;
        res.script_length = s.dec.py_end;
      end
      res.path_length = s.dec.q_found ? s.dec.q_pos : s.dec.count;
      res.decoded_length = s.dec.count;
      res.has_question = s.dec.q_found;
    end

    st_nxt = st_r;
    if (step) st_nxt = last_in ? clear_line() : s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= clear_line();
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/http_request_line_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_line_checker
// Streaming HTTP/1.1 request-line checker with one result per line.
// ----------------------------------------------------------------------------
// One byte is taken per clock while in_tready is high; a byte passes an input
// register, is folded into the line state by combinational logic, and the byte
// flagged by in_tlast loads the result register. Throughput is one item per cycle
// while in_tready is high; a finished result waiting on out_tready holds the next
// line's last byte in the input register, and only then does in_tready drop. The
// accepted last byte passes the input register, then loads the result register.
module http_request_line_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] line_byte
  input  wire logic        in_tlast,   // line_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] status, [4:3] method_kind, [6:5] ext_kind, [18:7] path_length,
  // [30:19] script_length, [42:31] decoded_length, [43] has_question
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data
);
  import hrlc_pkg::*;

  logic [LEN_BITS-1:0] max_len_r;
  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                in_last_r;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_res_r;
  result_t             res;
  logic                advance, step;

  assign cfg_ready = 1'b1;
  // a last byte waits only while the result register is still full
  assign advance   = !in_last_r || !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  hrlc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .last_in (in_last_r),
    .max_len (max_len_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (step && in_last_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= CFG_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) max_len_r <= cfg_data;
      if (in_tready) in_valid_r <= in_tvalid;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (step && in_last_r) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.has_question, out_res_r.decoded_length,
                       out_res_r.script_length, out_res_r.path_length,
                       out_res_r.ext_kind, out_res_r.method_kind, out_res_r.status};

endmodule
`default_nettype wire

// ===== src/hrlc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrlc_out_checks
// Port-level checks on the result stream of the request-line checker.
// ----------------------------------------------------------------------------
module hrlc_out_checks (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);
  import hrlc_pkg::*;

  // a result not taken stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // failed lines carry nothing but the status
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[47:3] == '0)
    else $error("failed line has nonzero fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_BAD_VER)
    else $error("status out of range");

  a_path_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:7] <= out_tdata[42:31])
    else $error("path longer than decoded target");

  // a script request always has the extension inside the path
  a_script_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:5] != EXT_NONE |-> out_tdata[30:19] != '0)
    else $error("script request without script length");

endmodule

bind http_request_line_checker hrlc_out_checks u_hrlc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
